@@ hw/rtl/rau_pkg.sv @@
// rational arithmetic unit package: opcodes, product selects, result width
// and the command/status structs between controller and datapath
// no dependencies
`default_nettype none

package rau_pkg;

  localparam int RES_W = 33;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] SEL_P0  = 2'd0;
  localparam logic [1:0] SEL_P1  = 2'd1;
  localparam logic [1:0] SEL_DEN = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       add_en;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init_num;
    logic       div_init_den;
    logic       div_step;
    logic       out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic gcd_done;
    logic div_done;
    logic out_free;
  } rau_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/rau_in_if.sv @@
// input channel of the rational arithmetic unit: valid/ready and operands
// depends on rau_pkg
`default_nettype none

interface rau_in_if #(
  parameter int W = 16
);
  import rau_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic signed [W-1:0] a_num;
  logic signed [W-1:0] a_den;
  logic signed [W-1:0] b_num;
  logic signed [W-1:0] b_den;

  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rau_out_if.sv @@
// result channel of the rational arithmetic unit: valid/ready and result
// depends on rau_pkg
`default_nettype none

interface rau_out_if;
  import rau_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] res_num;
  logic signed [RES_W-1:0] res_den;
  logic                    zero_den_error;

  modport source (output valid, res_num, res_den, zero_den_error, input ready);
  modport sink   (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rau_datapath.sv @@
// datapath: operand load, shared multiplier, signed add, binary gcd,
// restoring divider and result register; depends on rau_pkg, rau_out_if
`default_nettype none

module rau_datapath #(
  parameter int W = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  rau_pkg::rau_cmd_t          cmd_i,
  output rau_pkg::rau_sts_t          sts_o,
  input  wire [rau_pkg::CMD_W-1:0]   in_cmd,
  input  wire signed [W-1:0]         in_a_num,
  input  wire signed [W-1:0]         in_a_den,
  input  wire signed [W-1:0]         in_b_num,
  input  wire signed [W-1:0]         in_b_den,
  rau_out_if.source                  out_ch
);
  import rau_pkg::*;

  localparam int MW    = 2 * W;
  localparam int CNT_W = $clog2(MW + 1);

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [CMD_W-1:0] op_r;
  logic [W-1:0]     an_r, ad_r, bn_r, bd_r;
  logic             an_s_r, ad_s_r, bn_s_r, bd_s_r;

  logic [MW-1:0]    p0_r, p1_r, den_r, num_r;
  logic             p0_s_r, p1_s_r, den_s_r, num_s_r;

  logic [MW-1:0]    gx_r, gy_r, n_r, d_r;
  logic [MW-1:0]    rem_r, q_r, qn_r;
  logic [CNT_W-1:0] cnt_r;

  logic                    valid_r;
  logic signed [RES_W-1:0] res_num_r, res_den_r;
  logic                    err_r;

  // multiplier operand select
  logic [W-1:0]  mx, my;
  logic          mxs, mys;
  logic [MW-1:0] prod;
  logic          prod_s;

  always_comb begin
    mx  = an_r;
    mxs = an_s_r;
    my  = bd_r;
    mys = bd_s_r;
    unique case (cmd_i.mul_sel)
      SEL_P0: begin
        mx  = an_r;
        mxs = an_s_r;
        my  = (op_r == CMD_MUL) ? bn_r : bd_r;
        mys = (op_r == CMD_MUL) ? bn_s_r : bd_s_r;
      end
      SEL_P1: begin
        mx  = (op_r == CMD_ADD || op_r == CMD_SUB) ? ad_r : '0;
        mxs = ad_s_r;
        my  = bn_r;
        mys = bn_s_r;
      end
      default: begin
        mx  = ad_r;
        mxs = ad_s_r;
        my  = (op_r == CMD_DIV) ? bn_r : bd_r;
        mys = (op_r == CMD_DIV) ? bn_s_r : bd_s_r;
      end
    endcase
    prod   = MW'(mx) * MW'(my);
    prod_s = (prod != '0) && (mxs ^ mys);
  end

  // signed magnitude add
  logic          ys;
  logic [MW:0]   adif;
  logic [MW-1:0] sum_mag;
  logic          sum_s;

  always_comb begin
    ys   = p1_s_r ^ ((op_r == CMD_SUB) && (p1_r != '0));
    adif = {1'b0, p0_r} - {1'b0, p1_r};
    if (p0_s_r == ys) begin
      sum_mag = p0_r + p1_r;
      sum_s   = p0_s_r;
    end else if (!adif[MW]) begin
      sum_mag = adif[MW-1:0];
      sum_s   = p0_s_r;
    end else begin
      sum_mag = p1_r - p0_r;
      sum_s   = ys;
    end
    if (sum_mag == '0) begin
      sum_s = 1'b0;
    end
  end

  // binary gcd step and divider step
  logic [MW:0]   gdif;
  logic [MW-1:0] g_odd;
  logic [MW:0]   dshift, dtrial;

  always_comb begin
    gdif   = {1'b0, gx_r} - {1'b0, gy_r};
    g_odd  = gx_r | gy_r;
    dshift = {rem_r, q_r[MW-1]};
    dtrial = dshift - {1'b0, g_odd};
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r   <= in_cmd;
      an_r   <= mag_of(in_a_num);
      ad_r   <= mag_of(in_a_den);
      bn_r   <= mag_of(in_b_num);
      bd_r   <= mag_of(in_b_den);
      an_s_r <= in_a_num[W-1];
      ad_s_r <= in_a_den[W-1];
      bn_s_r <= in_b_num[W-1];
      bd_s_r <= in_b_den[W-1];
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        SEL_P0: begin
          p0_r   <= prod;
          p0_s_r <= prod_s;
        end
        SEL_P1: begin
          p1_r   <= prod;
          p1_s_r <= prod_s;
        end
        default: begin
          den_r   <= prod;
          den_s_r <= prod_s;
        end
      endcase
    end
    if (cmd_i.add_en) begin
      num_r   <= sum_mag;
      num_s_r <= sum_s;
    end
    if (cmd_i.gcd_init) begin
      gx_r <= num_r;
      gy_r <= den_r;
      n_r  <= num_r;
      d_r  <= den_r;
    end else if (cmd_i.gcd_step) begin
      priority if (!gx_r[0] && !gy_r[0]) begin
        gx_r <= gx_r >> 1;
        gy_r <= gy_r >> 1;
        n_r  <= n_r >> 1;
        d_r  <= d_r >> 1;
      end else if (!gx_r[0]) begin
        gx_r <= gx_r >> 1;
      end else if (!gy_r[0]) begin
        gy_r <= gy_r >> 1;
      end else if (!gdif[MW]) begin
        gx_r <= gdif[MW-1:0] >> 1;
      end else begin
        gy_r <= (gy_r - gx_r) >> 1;
      end
    end
    if (cmd_i.div_init_num) begin
      q_r   <= n_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd_i.div_init_den) begin
      qn_r  <= q_r;
      q_r   <= d_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd_i.div_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (!dtrial[MW]) begin
        rem_r <= dtrial[MW-1:0];
        q_r   <= {q_r[MW-2:0], 1'b1};
      end else begin
        rem_r <= dshift[MW-1:0];
        q_r   <= {q_r[MW-2:0], 1'b0};
      end
    end
  end

  // result register
  logic [RES_W-1:0] qn_f, qd_f;

  always_comb begin
    qn_f = RES_W'(qn_r);
    qd_f = RES_W'(q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      priority if (den_r == '0) begin
        res_num_r <= '0;
        res_den_r <= '0;
        err_r     <= 1'b1;
      end else if (num_r == '0) begin
        res_num_r <= '0;
        res_den_r <= RES_W'(1);
        err_r     <= 1'b0;
      end else begin
        res_num_r <= num_s_r ? -qn_f : qn_f;
        res_den_r <= den_s_r ? -qd_f : qd_f;
        err_r     <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.res_num        = res_num_r;
  assign out_ch.res_den        = res_den_r;
  assign out_ch.zero_den_error = err_r;

  assign sts_o.den_zero = (den_r == '0);
  assign sts_o.num_zero = (num_r == '0);
  assign sts_o.gcd_done = (gx_r == '0) || (gy_r == '0);
  assign sts_o.div_done = (cnt_r == CNT_W'(MW));
  assign sts_o.out_free = !valid_r || out_ch.ready;

endmodule

`default_nettype wire

@@ hw/rtl/rau_ctrl.sv @@
// controller state machine: sequences multiply, add, gcd, two divisions
// and the result load, skipping gcd and divisions for a zero term; depends on rau_pkg
`default_nettype none

module rau_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  rau_pkg::rau_sts_t sts_i,
  output rau_pkg::rau_cmd_t cmd_o
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL0  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_ADD   = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_GCD   = 4'd6;
  localparam logic [3:0] S_DIVN  = 4'd7;
  localparam logic [3:0] S_DIVD  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
        if (in_valid) begin
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = SEL_P0;
        state_nxt     = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = SEL_P1;
        state_nxt     = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = SEL_DEN;
        state_nxt     = S_ADD;
      end
      S_ADD: begin
        cmd_o.add_en = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.den_zero || sts_i.num_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_nxt      = S_GCD;
        end
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_init_num = 1'b1;
          state_nxt          = S_DIVN;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        if (sts_i.div_done) begin
          cmd_o.div_init_den = 1'b1;
          state_nxt          = S_DIVD;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DIVD: begin
        if (sts_i.div_done) begin
          state_nxt = S_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while output register busy");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_MUL0))
    else $error("accepted beat did not start the multiply sequence");

  a_gcd_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.gcd_step |-> !sts_i.gcd_done)
    else $error("gcd stepped after completion");

  a_div_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.div_step |-> !sts_i.div_done)
    else $error("divider stepped after completion");

endmodule

`default_nettype wire

@@ hw/rtl/rational_arithmetic_unit_top.sv @@
// rational arithmetic unit top: controller plus datapath on valid/ready channels
// an input beat runs through load, three multiplies, add, zero check, the gcd loop and two
// divisions to the result load and result valid; a zero term skips the gcd loop and divisions
// one beat in flight: a new input beat is taken only once the last result is loaded; a waiting
// result holds the next beat only while it blocks the result load
// synchronous active-low reset returns the controller to idle and empties the output
`default_nettype none

module rational_arithmetic_unit_top #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire       clk,
  input  wire       rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  rau_cmd_t cmd;
  rau_sts_t sts;
  logic     ctl_ready;

  assign in_ch.ready = ctl_ready;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  rau_datapath #(
    .W (OPERAND_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .in_cmd   (in_ch.cmd),
    .in_a_num (in_ch.a_num),
    .in_a_den (in_ch.a_den),
    .in_b_num (in_ch.b_num),
    .in_b_den (in_ch.b_den),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
